@@ hdl/dst_pkg.sv @@
// Shared constants and field layout for the allocation-site table.
package dst_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam int KEY_W    = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int ROWS_W   = 7;
  localparam int IN_W     = 96;
  localparam int OUT_W    = 48;

  // Command codes carried in the request tuser.
  localparam logic [FUNC_W-1:0] CMD_BEGIN       = 3'd0;
  localparam logic [FUNC_W-1:0] CMD_INSERT      = 3'd1;
  localparam logic [FUNC_W-1:0] CMD_FINISH      = 3'd2;
  localparam logic [FUNC_W-1:0] CMD_LOOKUP_SITE = 3'd3;
  localparam logic [FUNC_W-1:0] CMD_LOOKUP_FUNC = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_KEY   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_CONFLICT   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_NOT_CERT   = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_WRONG_MODE = 3'd6;

  localparam logic DISP_HEAP   = 1'b0;
  localparam logic DISP_REGION = 1'b1;

  // Result tdata bit positions.
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_FOUND_BIT  = 3;
  localparam int OUT_DISP_BIT   = 4;
  localparam int OUT_SCOPE_LSB  = 5;
  localparam int OUT_ROWS_LSB   = 37;

endpackage

@@ hdl/dedup_site_table.sv @@
// Allocation-site table with build, insert and lookup commands over one row memory.
//
// Requests arrive on the s_ channel: tuser carries the command, tdata the site
// key, scope and function id. Each request returns exactly one result on the
// m_ channel (status, found, disposition, scope and the current row count).
// The single configuration bit cert_ready is written through cfg_we/cfg_wdata.
//
// One request is handled at a time. Begin, finish and requests refused up front
// go from acceptance straight to the response state, which loads their result;
// the next request is taken after that. An insert or a lookup first scans the
// stored rows through the row memory in the scan state, one read per cycle, and
// then loads its result from the response state. A match ends the scan early.
// s_tready rises again once the result has been placed in the output register.
//
// Reset clears the row count, the build and verified flags and cert_ready; the
// row memory itself is not cleared, since only rows written during the current
// build are ever read. When the receiver stalls, the result holds in the
// output register and a finished request waits for it before loading.
module dedup_site_table #(
  parameter int TABLE_DEPTH = dst_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // site_id [31:0], scope_in [63:32], function_id [95:64]
  input  logic [dst_pkg::IN_W-1:0]      s_tdata,
  // func [2:0]
  input  logic [dst_pkg::FUNC_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status [2:0], found [3], disposition [4], scope_out [36:5],
  // rows_used [43:37], zero [47:44]
  output logic [dst_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = dst_pkg::KEY_W;
  localparam int RW = 3 * KW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]                    state;
  logic [dst_pkg::FUNC_W-1:0]    cmd_func;
  logic [KW-1:0]                 cmd_site;
  logic [KW-1:0]                 cmd_scope;
  logic [KW-1:0]                 cmd_fn;
  logic [CW-1:0]                 count;
  logic                          building;
  logic                          verified;
  logic                          cert;
  logic [CW-1:0]                 issue;
  logic                          rd_pend;
  logic [RW-1:0]                 rd_data;
  logic [dst_pkg::STATUS_W-1:0]  res_status;
  logic                          res_found;
  logic                          res_disp;
  logic [KW-1:0]                 res_scope;

  // Row memory: {function, scope, key} in one word.
  logic [RW-1:0] mem [TABLE_DEPTH];

  logic [KW-1:0] in_site;
  logic [KW-1:0] in_scope;
  logic [KW-1:0] in_fn;
  logic [KW-1:0] rd_key;
  logic [KW-1:0] rd_scope;
  logic [KW-1:0] rd_fn;
  logic          hit;
  logic          scan_more;
  logic          mem_re;
  logic          mem_we;
  logic          table_full;
  logic [dst_pkg::ROWS_W-1:0] rows_used;

  assign in_site  = s_tdata[KW-1:0];
  assign in_scope = s_tdata[2*KW-1:KW];
  assign in_fn    = s_tdata[3*KW-1:2*KW];

  assign rd_key   = rd_data[KW-1:0];
  assign rd_scope = rd_data[2*KW-1:KW];
  assign rd_fn    = rd_data[3*KW-1:2*KW];

  assign s_tready   = (state == S_IDLE);
  assign scan_more  = (issue < count);
  assign table_full = (count >= CW'(TABLE_DEPTH));
  assign rows_used  = dst_pkg::ROWS_W'(count);

  always_comb begin
    if (cmd_func == dst_pkg::CMD_LOOKUP_FUNC) begin
      hit = rd_pend && (rd_fn == cmd_fn);
    end else begin
      hit = rd_pend && (rd_key == cmd_site);
    end
  end

  assign mem_re = (state == S_SCAN) && !hit && scan_more;
  // A new row is written only when the scan has found no copy of the key.
  assign mem_we = (state == S_SCAN) && !hit && !scan_more &&
                  (cmd_func == dst_pkg::CMD_INSERT) && !table_full;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= {cmd_fn, cmd_scope, cmd_site};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[issue[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      building <= 1'b0;
      verified <= 1'b0;
      cert     <= 1'b0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cert <= cfg_wdata;
      end
      rd_pend <= 1'b0;
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_func   <= s_tuser;
            cmd_site   <= in_site;
            cmd_scope  <= in_scope;
            cmd_fn     <= in_fn;
            issue      <= '0;
            res_status <= dst_pkg::STATUS_OK;
            res_found  <= 1'b0;
            res_disp   <= dst_pkg::DISP_HEAP;
            res_scope  <= '0;
            state      <= S_RESP;
            case (s_tuser)
              dst_pkg::CMD_BEGIN: begin
                count    <= '0;
                verified <= 1'b0;
                building <= cert;
                if (!cert) begin
                  res_status <= dst_pkg::STATUS_NOT_CERT;
                end
              end
              dst_pkg::CMD_INSERT: begin
                if (!building) begin
                  res_status <= dst_pkg::STATUS_WRONG_MODE;
                end else if (in_site == '0) begin
                  count      <= '0;
                  verified   <= 1'b0;
                  building   <= 1'b0;
                  res_status <= dst_pkg::STATUS_ZERO_KEY;
                end else begin
                  state <= S_SCAN;
                end
              end
              dst_pkg::CMD_FINISH: begin
                if (!building) begin
                  res_status <= dst_pkg::STATUS_WRONG_MODE;
                end else begin
                  verified <= 1'b1;
                  building <= 1'b0;
                end
              end
              dst_pkg::CMD_LOOKUP_SITE: begin
                res_status <= dst_pkg::STATUS_NOT_FOUND;
                if (verified && in_site != '0) begin
                  state <= S_SCAN;
                end
              end
              dst_pkg::CMD_LOOKUP_FUNC: begin
                res_status <= dst_pkg::STATUS_NOT_FOUND;
                if (verified && in_fn != '0) begin
                  state <= S_SCAN;
                end
              end
              default: begin
                res_status <= dst_pkg::STATUS_WRONG_MODE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            state <= S_RESP;
            case (cmd_func)
              dst_pkg::CMD_INSERT: begin
                if (rd_scope != cmd_scope || rd_fn != cmd_fn) begin
                  count      <= '0;
                  verified   <= 1'b0;
                  building   <= 1'b0;
                  res_status <= dst_pkg::STATUS_CONFLICT;
                end
              end
              dst_pkg::CMD_LOOKUP_SITE: begin
                res_status <= dst_pkg::STATUS_OK;
                res_found  <= 1'b1;
                res_disp   <= dst_pkg::DISP_REGION;
                res_scope  <= rd_scope;
              end
              default: begin
                // The first row with this function decides, even with a zero scope.
                if (rd_scope != '0) begin
                  res_status <= dst_pkg::STATUS_OK;
                  res_found  <= 1'b1;
                  res_scope  <= rd_scope;
                end
              end
            endcase
          end else if (scan_more) begin
            issue   <= issue + CW'(1);
            rd_pend <= 1'b1;
          end else begin
            state <= S_RESP;
            if (cmd_func == dst_pkg::CMD_INSERT) begin
              if (table_full) begin
                res_status <= dst_pkg::STATUS_FULL;
              end else begin
                count <= count + CW'(1);
              end
            end
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, rows_used, res_scope, res_disp, res_found, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/dst_checker.sv @@
// Port-level checks for the allocation-site table and their bind to the top level.
module dst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dst_pkg::OUT_W-1:0]     m_tdata
);

  logic [dst_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic                         disp;
  logic [dst_pkg::KEY_W-1:0]    scope;

  assign status = m_tdata[dst_pkg::OUT_STATUS_LSB +: dst_pkg::STATUS_W];
  assign found  = m_tdata[dst_pkg::OUT_FOUND_BIT];
  assign disp   = m_tdata[dst_pkg::OUT_DISP_BIT];
  assign scope  = m_tdata[dst_pkg::OUT_SCOPE_LSB +: dst_pkg::KEY_W];

  // A stalled result keeps its value until taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A matched row always reports success.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && found |-> status == dst_pkg::STATUS_OK)
    else $error("found set with a failing status");

  // Region disposition only comes with a match, and no match carries no scope.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !found |-> !disp && scope == '0)
    else $error("scope or disposition without a match");

endmodule

bind dedup_site_table dst_checker u_dst_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/dedup_site_table_tb.sv @@
// Self-checking testbench for the allocation-site table: directed table, random builds, lookups.
`timescale 1ns / 100ps

module dedup_site_table_tb;
  import dst_pkg::*;

  localparam int TBL_DEPTH    = DEFAULT_TABLE_DEPTH;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1850;
  localparam int NO_CFG       = -1;

  // Command codes the block does not define; they must be refused.
  localparam logic [FUNC_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [FUNC_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic                disp;
    logic [KEY_W-1:0]    scope;
    logic [ROWS_W-1:0]   rows;
  } site_result_t;

  typedef struct {
    int                cfg;
    logic [FUNC_W-1:0] cmd;
    logic [KEY_W-1:0]  site;
    logic [KEY_W-1:0]  scope;
    logic [KEY_W-1:0]  fn;
    bit                typed;
    site_result_t      res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  // Predictor state: a private copy of the table and the control flags.
  logic [KEY_W-1:0] tbl_key   [TBL_DEPTH];
  logic [KEY_W-1:0] tbl_scope [TBL_DEPTH];
  logic [KEY_W-1:0] tbl_fn    [TBL_DEPTH];
  int unsigned      row_cnt = 0;
  bit               building = 1'b0;
  bit               verified = 1'b0;
  bit               cert_bit = 1'b0;

  site_result_t pending_results[$];
  dir_row_t     dir_rows[$];
  site_result_t got;
  site_result_t want;

  int errors = 0;
  int items_done = 0;
  int burst_left = 0;
  int cycle_cnt = 0;
  int n_builds = 0;
  int n_cfg = 0;
  int n_full = 0;
  int n_conflict = 0;
  int n_site_hit = 0;
  int n_func_hit = 0;
  int n_hold = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  dedup_site_table #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results pending", $time,
               pending_results.size());
      $display("** dedup_site_table: FAILED **");
      $finish;
    end
  end

  function automatic void clear_build();
    row_cnt = 0;
    verified = 1'b0;
    building = 1'b0;
  endfunction

  function automatic site_result_t predict_table(input logic [FUNC_W-1:0] cmd,
                                                 input logic [KEY_W-1:0] site,
                                                 input logic [KEY_W-1:0] scope,
                                                 input logic [KEY_W-1:0] fn);
    site_result_t r;
    int hit;
    r = '0;
    r.status = STATUS_OK;
    r.disp = DISP_HEAP;
    hit = -1;
    case (cmd)
      CMD_BEGIN: begin
        clear_build();
        if (!cert_bit) r.status = STATUS_NOT_CERT;
        else building = 1'b1;
      end
      CMD_INSERT: begin
        if (!building) begin
          r.status = STATUS_WRONG_MODE;
        end else if (site == '0) begin
          clear_build();
          r.status = STATUS_ZERO_KEY;
        end else begin
          for (int i = 0; i < row_cnt; i++)
            if (hit < 0 && tbl_key[i] == site) hit = i;
          if (hit >= 0) begin
            // An exact duplicate is silently accepted; any difference aborts the build.
            if (tbl_scope[hit] != scope || tbl_fn[hit] != fn) begin
              clear_build();
              r.status = STATUS_CONFLICT;
              n_conflict++;
            end
          end else if (row_cnt >= TBL_DEPTH) begin
            r.status = STATUS_FULL;
            n_full++;
          end else begin
            tbl_key[row_cnt] = site;
            tbl_scope[row_cnt] = scope;
            tbl_fn[row_cnt] = fn;
            row_cnt++;
          end
        end
      end
      CMD_FINISH: begin
        if (!building) begin
          r.status = STATUS_WRONG_MODE;
        end else begin
          verified = 1'b1;
          building = 1'b0;
        end
      end
      CMD_LOOKUP_SITE: begin
        r.status = STATUS_NOT_FOUND;
        if (verified && site != '0) begin
          for (int i = 0; i < row_cnt; i++)
            if (hit < 0 && tbl_key[i] == site) hit = i;
          if (hit >= 0) begin
            r.status = STATUS_OK;
            r.found = 1'b1;
            r.disp = DISP_REGION;
            r.scope = tbl_scope[hit];
            n_site_hit++;
          end
        end
      end
      CMD_LOOKUP_FUNC: begin
        r.status = STATUS_NOT_FOUND;
        if (verified && fn != '0) begin
          for (int i = 0; i < row_cnt; i++)
            if (hit < 0 && tbl_fn[i] == fn) hit = i;
          // Only the first row with this function counts, even when its scope is zero.
          if (hit >= 0 && tbl_scope[hit] != '0) begin
            r.status = STATUS_OK;
            r.found = 1'b1;
            r.scope = tbl_scope[hit];
            n_func_hit++;
          end
        end
      end
      default: r.status = STATUS_WRONG_MODE;
    endcase
    r.rows = row_cnt[ROWS_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [KEY_W-1:0] exp_val,
                             input logic [KEY_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting: expected none, actual %h",
                 $time, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        got.status = m_tdata[OUT_STATUS_LSB +: STATUS_W];
        got.found = m_tdata[OUT_FOUND_BIT];
        got.disp = m_tdata[OUT_DISP_BIT];
        got.scope = m_tdata[OUT_SCOPE_LSB +: KEY_W];
        got.rows = m_tdata[OUT_ROWS_LSB +: ROWS_W];
        check_field("status", KEY_W'(want.status), KEY_W'(got.status));
        check_field("found", KEY_W'(want.found), KEY_W'(got.found));
        check_field("disposition", KEY_W'(want.disp), KEY_W'(got.disp));
        check_field("scope_out", want.scope, got.scope);
        check_field("rows_used", KEY_W'(want.rows), KEY_W'(got.rows));
        check_field("pad", '0, KEY_W'(m_tdata[OUT_W-1:OUT_ROWS_LSB+ROWS_W]));
      end
    end
  end

  // Result side: the stall pattern changes now and then; one long hold-off on request.
  initial begin
    rx_mode_t mode;
    int cnt;
    int hold_left;
    mode = RX_ALWAYS;
    cnt = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cnt++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        n_hold++;
      end
      if (cnt % 97 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: m_tready <= 1'b1;
          RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offers one request and returns at the edge where it is taken.
  task automatic send_item(input logic [FUNC_W-1:0] cmd, input logic [KEY_W-1:0] site,
                           input logic [KEY_W-1:0] scope, input logic [KEY_W-1:0] fn,
                           input bit typed, input site_result_t typed_res);
    site_result_t p;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    p = predict_table(cmd, site, scope, fn);
    pending_results.push_back(typed ? typed_res : p);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {fn, scope, site};
    do @(posedge clk); while (!s_tready);
    items_done++;
  endtask

  task automatic req(input logic [FUNC_W-1:0] cmd, input logic [KEY_W-1:0] site,
                     input logic [KEY_W-1:0] scope, input logic [KEY_W-1:0] fn);
    send_item(cmd, site, scope, fn, 1'b0, '0);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_cert(input logic val);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cert_bit = val;
    n_cfg++;
  endtask

  task automatic add_row(input int cfg, input logic [FUNC_W-1:0] cmd,
                         input logic [KEY_W-1:0] site, input logic [KEY_W-1:0] scope,
                         input logic [KEY_W-1:0] fn, input bit typed,
                         input logic [STATUS_W-1:0] st, input logic [ROWS_W-1:0] rows);
    dir_row_t d;
    d.cfg = cfg;
    d.cmd = cmd;
    d.site = site;
    d.scope = scope;
    d.fn = fn;
    d.typed = typed;
    d.res = '0;
    d.res.status = st;
    d.res.disp = DISP_HEAP;
    d.res.rows = rows;
    dir_rows.push_back(d);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = $urandom; while (k == '0);
    return k;
  endfunction

  // A begin, a series of inserts, usually a finish, then lookups against what was stored.
  task automatic run_build();
    logic [KEY_W-1:0] keys[$];
    logic [KEY_W-1:0] scopes[$];
    logic [KEY_W-1:0] fns[$];
    logic [KEY_W-1:0] fn_pool[4];
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] s;
    logic [KEY_W-1:0] f;
    int n_ins;
    int pick;
    int idx;
    bit big;
    n_builds++;
    foreach (fn_pool[i]) fn_pool[i] = fresh_key();
    big = ($urandom_range(0, 7) == 0);
    n_ins = big ? $urandom_range(TBL_DEPTH, TBL_DEPTH + 8) : $urandom_range(1, 12);
    req(CMD_BEGIN, $urandom, $urandom, $urandom);
    repeat (n_ins) begin
      pick = $urandom_range(0, 999);
      idx = (keys.size() > 0) ? $urandom_range(0, keys.size() - 1) : 0;
      if (keys.size() > 0 && pick < 60) begin
        req(CMD_INSERT, keys[idx], scopes[idx], fns[idx]);
      end else if (!big && keys.size() > 0 && pick < 80) begin
        if (pick[0]) req(CMD_INSERT, keys[idx], scopes[idx] ^ (32'd1 << $urandom_range(0, 31)),
                         fns[idx]);
        else req(CMD_INSERT, keys[idx], scopes[idx], fns[idx] ^ (32'd1 << $urandom_range(0, 31)));
      end else if (!big && pick < 95) begin
        req(CMD_INSERT, '0, $urandom, $urandom);
      end else begin
        k = fresh_key();
        s = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
        f = ($urandom_range(0, 2) == 0) ? $urandom : fn_pool[$urandom_range(0, 3)];
        req(CMD_INSERT, k, s, f);
        keys.push_back(k);
        scopes.push_back(s);
        fns.push_back(f);
      end
    end
    if ($urandom_range(0, 11) != 0) req(CMD_FINISH, $urandom, $urandom, $urandom);
    repeat ($urandom_range(2, 10)) begin
      pick = $urandom_range(0, 9);
      idx = (keys.size() > 0) ? $urandom_range(0, keys.size() - 1) : 0;
      if (pick < 4 && keys.size() > 0) req(CMD_LOOKUP_SITE, keys[idx], $urandom, $urandom);
      else if (pick < 5) req(CMD_LOOKUP_SITE, $urandom, $urandom, $urandom);
      else if (pick < 6) req(CMD_LOOKUP_SITE, '0, $urandom, $urandom);
      else if (pick < 8) req(CMD_LOOKUP_FUNC, $urandom, $urandom, fn_pool[$urandom_range(0, 3)]);
      else if (pick < 9) req(CMD_LOOKUP_FUNC, $urandom, $urandom, $urandom);
      else req(CMD_LOOKUP_FUNC, $urandom, $urandom, '0);
    end
  endtask

  initial begin
    int pick;
    int dir_count;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // cfg, command, site, scope, function, typed, status, rows
    add_row(NO_CFG, CMD_LOOKUP_SITE, 32'd1, 32'd0, 32'd0, 1, STATUS_NOT_FOUND, 0);
    add_row(NO_CFG, CMD_INSERT, 32'd5, 32'd6, 32'd7, 1, STATUS_WRONG_MODE, 0);
    add_row(NO_CFG, CMD_FINISH, 32'd0, 32'd0, 32'd0, 1, STATUS_WRONG_MODE, 0);
    add_row(NO_CFG, CMD_BEGIN, 32'd0, 32'd0, 32'd0, 1, STATUS_NOT_CERT, 0);
    add_row(NO_CFG, CMD_SPARE_5, '1, '1, '1, 1, STATUS_WRONG_MODE, 0);
    add_row(NO_CFG, CMD_SPARE_6, 32'd0, '1, 32'd0, 1, STATUS_WRONG_MODE, 0);
    add_row(NO_CFG, CMD_SPARE_7, '1, 32'd0, '1, 1, STATUS_WRONG_MODE, 0);
    add_row(1, CMD_BEGIN, 32'd0, 32'd0, 32'd0, 1, STATUS_OK, 0);
    add_row(NO_CFG, CMD_INSERT, '1, '1, '1, 1, STATUS_OK, 1);
    add_row(NO_CFG, CMD_INSERT, 32'd1, 32'd0, 32'd5, 1, STATUS_OK, 2);
    add_row(NO_CFG, CMD_INSERT, '1, '1, '1, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_INSERT, 32'd2, 32'd7, 32'd5, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_LOOKUP_SITE, 32'd2, 32'd0, 32'd0, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_FINISH, 32'd0, 32'd0, 32'd0, 1, STATUS_OK, 3);
    add_row(NO_CFG, CMD_LOOKUP_SITE, '1, 32'd0, 32'd0, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_LOOKUP_SITE, 32'd0, '1, '1, 1, STATUS_NOT_FOUND, 3);
    add_row(NO_CFG, CMD_LOOKUP_FUNC, '1, '1, 32'd0, 1, STATUS_NOT_FOUND, 3);
    add_row(NO_CFG, CMD_LOOKUP_FUNC, 32'd0, 32'd0, 32'd5, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_LOOKUP_FUNC, 32'd0, 32'd0, '1, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_LOOKUP_SITE, 32'd3, 32'd0, 32'd0, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_BEGIN, 32'd0, 32'd0, 32'd0, 1, STATUS_OK, 0);
    add_row(NO_CFG, CMD_INSERT, 32'd9, 32'd9, 32'd9, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_BEGIN, 32'd0, 32'd0, 32'd0, 1, STATUS_OK, 0);
    add_row(NO_CFG, CMD_INSERT, 32'd0, 32'd1, 32'd1, 1, STATUS_ZERO_KEY, 0);
    add_row(NO_CFG, CMD_INSERT, 32'd4, 32'd1, 32'd1, 1, STATUS_WRONG_MODE, 0);
    add_row(NO_CFG, CMD_BEGIN, 32'd0, 32'd0, 32'd0, 1, STATUS_OK, 0);
    add_row(NO_CFG, CMD_INSERT, 32'd4, 32'd1, 32'd1, 0, STATUS_OK, 0);
    add_row(NO_CFG, CMD_INSERT, 32'd4, 32'd2, 32'd1, 1, STATUS_CONFLICT, 0);
    add_row(NO_CFG, CMD_LOOKUP_SITE, 32'd4, 32'd0, 32'd0, 0, STATUS_OK, 0);
    add_row(0, CMD_BEGIN, 32'd0, 32'd0, 32'd0, 1, STATUS_NOT_CERT, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != NO_CFG) write_cert(dir_rows[i].cfg[0]);
      send_item(dir_rows[i].cmd, dir_rows[i].site, dir_rows[i].scope, dir_rows[i].fn,
                dir_rows[i].typed, dir_rows[i].res);
    end
    dir_count = items_done;

    write_cert(1'b1);
    while (items_done < dir_count + RANDOM_ITEMS) begin
      // Once, the result side holds off long enough for the request side to back up.
      if (!hold_done && items_done > dir_count + 600) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        run_build();
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4))
          req(FUNC_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
      end else begin
        write_cert(($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TBL_DEPTH + 8) @(posedge clk);

    $display("Ran %0d requests (%0d directed) over %0d random builds and %0d cert_ready writes.",
             items_done, dir_count, n_builds, n_cfg);
    $display("Saw %0d full-table drops, %0d conflicts, %0d site hits, %0d function hits,",
             n_full, n_conflict, n_site_hit, n_func_hit);
    $display("and %0d long result hold-offs.", n_hold);
    if (errors == 0) begin
      $display("** dedup_site_table: PASSED **");
    end else begin
      $display("** dedup_site_table: FAILED **");
    end
    $finish;
  end

endmodule
